### hw/rtl/rcfd_pkg.sv
// ---------------------------------------------------------------------------
// rcfd_pkg
// Types, codes and helper functions shared by the radio frame decoder.
// ---------------------------------------------------------------------------
package rcfd_pkg;

    localparam int POS_W         = 6;
    localparam int MAX_CH        = 8;
    localparam int CH_FIRST_BYTE = 4;
    localparam int CFG_IDX_W     = 4;

    localparam logic [7:0] HDR0 = 8'hAA;
    localparam logic [7:0] HDR1 = 8'hAF;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_POLL = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD   = 2'd1;
    localparam logic [1:0] ST_NOPKT = 2'd2;
    localparam logic [1:0] ST_LOST  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_MIN    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_MAX    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_CENTER = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_GAIN   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_HIGH    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_LOW     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_STEP    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LOSS_LIMIT  = 4'd7;

    typedef logic [POS_W-1:0]             t_pos;
    typedef logic [15:0]                  t_chan;
    typedef logic [MAX_CH-1:0][15:0]      t_chan_vec;
    typedef logic [CFG_IDX_W-1:0]         t_cfg_idx;

    typedef struct packed {
        logic last;
        logic ok;
    } t_frame_evt;

    typedef struct packed {
        t_chan       chan_min;
        t_chan       chan_max;
        t_chan       chan_center;
        logic [7:0]  tilt_gain;
        t_chan       yaw_high;
        t_chan       yaw_low;
        logic [9:0]  yaw_step;
    } t_cmt_cfg;

    typedef struct packed {
        t_chan_vec          chan;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [23:0] yaw;
    } t_cmt_view;

    typedef struct packed {
        logic [1:0] status;
        t_cmt_view  view;
    } t_result;

    function automatic t_chan clamp_chan(input t_chan v, input t_chan lo, input t_chan hi);
        t_chan r;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [25:0] v);
        logic signed [15:0] r;
        if (v > 26'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -26'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
        logic signed [23:0] r;
        if (v > 25'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -25'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

### hw/rtl/rcfd_ifs.sv
// ---------------------------------------------------------------------------
// rcfd_ifs
// Valid/ready channels of the radio frame decoder: input, result, config.
// ---------------------------------------------------------------------------
interface rcfd_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;

    modport source (output valid, output func, output data_byte, input ready);
    modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface rcfd_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [15:0]        roll_channel;
    logic [15:0]        pitch_channel;
    logic [15:0]        throttle_channel;
    logic [15:0]        yaw_channel;
    logic [15:0]        aux_one;
    logic [15:0]        aux_two;
    logic [15:0]        aux_three;
    logic [15:0]        aux_four;
    logic signed [15:0] roll_target;
    logic signed [15:0] pitch_target;
    logic signed [23:0] yaw_target;

    modport source (
        output valid, input ready, output status,
        output roll_channel, output pitch_channel, output throttle_channel,
        output yaw_channel, output aux_one, output aux_two, output aux_three,
        output aux_four, output roll_target, output pitch_target, output yaw_target
    );
    modport sink (
        input valid, output ready, input status,
        input roll_channel, input pitch_channel, input throttle_channel,
        input yaw_channel, input aux_one, input aux_two, input aux_three,
        input aux_four, input roll_target, input pitch_target, input yaw_target
    );
endinterface

interface rcfd_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/rc_frame_decoder.sv
// ---------------------------------------------------------------------------
// rc_frame_decoder
// Radio control frame decoder: byte-wise frame check, channel commit,
// tilt and yaw targets, and link loss tracking.
// ---------------------------------------------------------------------------
//  port    dir  role           beat
//  i_in    in   byte or poll   func, data_byte
//  o_out   out  frame result   status, eight channels, three targets
//  i_cfg   in   register write index, data (always ready)
//
//  One beat per cycle unless a result beat waits on a stalled output. A beat
//  is held in the input register, then the result (polls and last frame bytes
//  only) lands in the output register. Other bytes leave no result.
//  A stalled output holds the result; the input register drains into it
//  once taken. Synchronous active-low reset; no clearing pass.
// ---------------------------------------------------------------------------
module rc_frame_decoder #(
    parameter int FRAME_BYTES   = 32,
    parameter int CHANNEL_COUNT = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rcfd_in_if.sink    i_in,
    rcfd_out_if.source o_out,
    rcfd_cfg_if.sink   i_cfg
);
    import rcfd_pkg::*;

    logic       r_in_valid;
    logic       r_in_func;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_result    n_out;

    t_cmt_cfg   r_cfg;
    t_chan      r_loss_limit;
    t_chan      r_loss, n_loss;
    t_chan      loss_inc;

    t_frame_evt evt;
    t_chan_vec  staged;
    t_cmt_view  view;
    logic       has_result;
    logic       out_free;
    logic       advance;
    logic       commit;

    assign has_result = (r_in_func == FUNC_POLL) || evt.last;
    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && (!has_result || out_free);
    assign commit     = advance && (r_in_func == FUNC_BYTE) && evt.last && evt.ok;
    assign i_in.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    rcfd_frame_track #(
        .FRAME_BYTES   (FRAME_BYTES),
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_func   (r_in_func),
        .i_byte   (r_in_byte),
        .o_evt    (evt),
        .o_staged (staged)
    );

    rcfd_commit #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_commit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (commit),
        .i_cfg    (r_cfg),
        .i_staged (staged),
        .o_next   (view)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_func <= i_in.func;
            r_in_byte <= i_in.data_byte;
        end
    end

    // loss counter and status
    assign loss_inc = r_loss + t_chan'(1);

    always_comb begin
        n_loss       = r_loss;
        n_out.view   = view;
        n_out.status = ST_OK;
        if (r_in_func == FUNC_POLL) begin
            if (loss_inc > r_loss_limit) begin
                n_loss       = '0;
                n_out.status = ST_LOST;
            end else begin
                n_loss       = loss_inc;
                n_out.status = ST_NOPKT;
            end
        end else begin
            n_loss       = '0;
            n_out.status = evt.ok ? ST_OK : ST_BAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loss <= '0;
        end else if (advance && has_result) begin
            r_loss <= n_loss;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && has_result) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.status           = r_out.status;
    assign o_out.roll_channel     = r_out.view.chan[0];
    assign o_out.pitch_channel    = r_out.view.chan[1];
    assign o_out.throttle_channel = r_out.view.chan[2];
    assign o_out.yaw_channel      = r_out.view.chan[3];
    assign o_out.aux_one          = r_out.view.chan[4];
    assign o_out.aux_two          = r_out.view.chan[5];
    assign o_out.aux_three        = r_out.view.chan[6];
    assign o_out.aux_four         = r_out.view.chan[7];
    assign o_out.roll_target      = r_out.view.roll;
    assign o_out.pitch_target     = r_out.view.pitch;
    assign o_out.yaw_target       = r_out.view.yaw;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.chan_min    <= 16'd1000;
            r_cfg.chan_max    <= 16'd2000;
            r_cfg.chan_center <= 16'd1500;
            r_cfg.tilt_gain   <= 8'd4;
            r_cfg.yaw_high    <= 16'd1820;
            r_cfg.yaw_low     <= 16'd1180;
            r_cfg.yaw_step    <= 10'd75;
            r_loss_limit      <= 16'd800;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_CHAN_MIN:    r_cfg.chan_min    <= i_cfg.data;
                CFG_CHAN_MAX:    r_cfg.chan_max    <= i_cfg.data;
                CFG_CHAN_CENTER: r_cfg.chan_center <= i_cfg.data;
                CFG_TILT_GAIN:   r_cfg.tilt_gain   <= i_cfg.data[7:0];
                CFG_YAW_HIGH:    r_cfg.yaw_high    <= i_cfg.data;
                CFG_YAW_LOW:     r_cfg.yaw_low     <= i_cfg.data;
                CFG_YAW_STEP:    r_cfg.yaw_step    <= i_cfg.data[9:0];
                CFG_LOSS_LIMIT:  r_loss_limit      <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

endmodule

### hw/rtl/rcfd_frame_track.sv
// ---------------------------------------------------------------------------
// rcfd_frame_track
// Byte position, running sum, header check and channel staging per frame.
// ---------------------------------------------------------------------------
module rcfd_frame_track #(
    parameter int FRAME_BYTES   = 32,
    parameter int CHANNEL_COUNT = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_func,
    input  logic [7:0]          i_byte,
    output rcfd_pkg::t_frame_evt o_evt,
    output rcfd_pkg::t_chan_vec  o_staged
);
    import rcfd_pkg::*;

    localparam t_pos LAST_POS = t_pos'(FRAME_BYTES - 1);

    t_pos       r_pos, n_pos;
    logic [7:0] r_sum, n_sum;
    logic       r_hdr_ok, n_hdr_ok;
    logic       hdr_now;
    logic       is_last;

    assign is_last = (r_pos >= LAST_POS);
    assign hdr_now = r_hdr_ok
                   && !((r_pos == t_pos'(0)) && (i_byte != HDR0))
                   && !((r_pos == t_pos'(1)) && (i_byte != HDR1));

    assign o_evt.last = is_last;
    assign o_evt.ok   = hdr_now && (i_byte == r_sum);

    always_comb begin
        n_pos    = r_pos;
        n_sum    = r_sum;
        n_hdr_ok = r_hdr_ok;
        if (i_step) begin
            if (i_func == FUNC_POLL || is_last) begin
                n_pos    = '0;
                n_sum    = '0;
                n_hdr_ok = 1'b1;
            end else begin
                n_pos    = r_pos + t_pos'(1);
                n_sum    = r_sum + i_byte;
                n_hdr_ok = hdr_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_sum    <= '0;
            r_hdr_ok <= 1'b1;
        end else begin
            r_pos    <= n_pos;
            r_sum    <= n_sum;
            r_hdr_ok <= n_hdr_ok;
        end
    end

    for (genvar k = 0; k < MAX_CH; k++) begin : g_stage
        if (k < CHANNEL_COUNT) begin : g_used
            localparam t_pos HI_POS = t_pos'(CH_FIRST_BYTE + 2 * k);
            localparam t_pos LO_POS = t_pos'(CH_FIRST_BYTE + 2 * k + 1);
            t_chan r_staged;
            always_ff @(posedge i_clk) begin
                if (i_step && i_func == FUNC_BYTE) begin
                    if (r_pos == HI_POS) begin
                        r_staged[15:8] <= i_byte;
                    end
                    if (r_pos == LO_POS) begin
                        r_staged[7:0] <= i_byte;
                    end
                end
            end
            assign o_staged[k] = r_staged;
        end else begin : g_unused
            assign o_staged[k] = '0;
        end
    end

endmodule

### hw/rtl/rcfd_commit.sv
// ---------------------------------------------------------------------------
// rcfd_commit
// Committed channels with clamping, roll/pitch tilt targets, yaw integrator.
// ---------------------------------------------------------------------------
module rcfd_commit #(
    parameter int CHANNEL_COUNT = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_commit,
    input  rcfd_pkg::t_cmt_cfg  i_cfg,
    input  rcfd_pkg::t_chan_vec i_staged,
    output rcfd_pkg::t_cmt_view o_next
);
    import rcfd_pkg::*;

    t_chan_vec          r_chan, n_chan;
    logic signed [15:0] r_roll, n_roll;
    logic signed [15:0] r_pitch, n_pitch;
    logic signed [23:0] r_yaw, n_yaw;
    logic signed [16:0] d_roll, d_pitch;
    logic signed [25:0] p_roll, p_pitch;
    logic signed [25:0] gain_ext;
    logic signed [24:0] y_sum;

    for (genvar k = 0; k < MAX_CH; k++) begin : g_clamp
        if (k < CHANNEL_COUNT) begin : g_used
            assign n_chan[k] = i_commit
                             ? clamp_chan(i_staged[k], i_cfg.chan_min, i_cfg.chan_max)
                             : r_chan[k];
        end else begin : g_unused
            assign n_chan[k] = r_chan[k];
        end
    end

    assign gain_ext = $signed({18'd0, i_cfg.tilt_gain});
    assign d_roll   = $signed({1'b0, n_chan[0]}) - $signed({1'b0, i_cfg.chan_center});
    assign d_pitch  = $signed({1'b0, n_chan[1]}) - $signed({1'b0, i_cfg.chan_center});
    assign p_roll   = {{9{d_roll[16]}}, d_roll} * gain_ext;
    assign p_pitch  = {{9{d_pitch[16]}}, d_pitch} * gain_ext;

    always_comb begin
        y_sum = {r_yaw[23], r_yaw};
        if (n_chan[3] > i_cfg.yaw_high) begin
            y_sum = y_sum + $signed({15'd0, i_cfg.yaw_step});
        end else if (n_chan[3] < i_cfg.yaw_low) begin
            y_sum = y_sum - $signed({15'd0, i_cfg.yaw_step});
        end
    end

    assign n_roll  = i_commit ? sat16(-p_roll) : r_roll;
    assign n_pitch = i_commit ? sat16(-p_pitch) : r_pitch;
    assign n_yaw   = i_commit ? sat24(y_sum) : r_yaw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan  <= '0;
            r_roll  <= '0;
            r_pitch <= '0;
            r_yaw   <= '0;
        end else begin
            r_chan  <= n_chan;
            r_roll  <= n_roll;
            r_pitch <= n_pitch;
            r_yaw   <= n_yaw;
        end
    end

    assign o_next.chan  = n_chan;
    assign o_next.roll  = n_roll;
    assign o_next.pitch = n_pitch;
    assign o_next.yaw   = n_yaw;

endmodule

### test/tb_rc_frame_decoder.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_rc_frame_decoder
// Self-checking bench for the radio frame decoder. Good, broken, noisy and
// cut-off frames and polls go in with random gaps. The output side stalls
// at random. A local model of the decoder predicts every report, and each
// report taken from the output is compared field by field. Register
// settings change between phases, only while the decoder is idle.
// ---------------------------------------------------------------------------
module tb_rc_frame_decoder;
    import rcfd_pkg::*;

    localparam int FRAME_BYTES   = 32;
    localparam int CHANNEL_COUNT = 8;
    localparam int LATENCY       = 2;
    localparam int STALL_LIMIT   = 1000;
    localparam int MAX_REPORTS   = 10;

    typedef enum int {FLAW_NONE, FLAW_HDR0, FLAW_HDR1, FLAW_SUM, FLAW_NOISE} t_flaw;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rcfd_in_if  in_if ();
    rcfd_out_if out_if ();
    rcfd_cfg_if cfg_if ();

    rc_frame_decoder #(
        .FRAME_BYTES   (FRAME_BYTES),
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // register mirror, reset values
    t_chan      cfg_min    = 16'd1000;
    t_chan      cfg_max    = 16'd2000;
    t_chan      cfg_center = 16'd1500;
    logic [7:0] cfg_gain   = 8'd4;
    t_chan      cfg_yhigh  = 16'd1820;
    t_chan      cfg_ylow   = 16'd1180;
    logic [9:0] cfg_ystep  = 10'd75;
    t_chan      cfg_loss   = 16'd800;

    // decoder model state
    int                 pos_count  = 0;
    logic [7:0]         byte_sum   = 8'd0;
    bit                 header_ok  = 1'b1;
    t_chan_vec          staged_ch  = '0;
    t_chan_vec          live_ch    = '0;
    logic signed [15:0] roll_tgt   = '0;
    logic signed [15:0] pitch_tgt  = '0;
    logic signed [23:0] yaw_acc    = '0;
    logic [15:0]        miss_count = '0;

    t_result expected_reports[$];

    bit steady      = 1'b0;
    int idle_cycles = 0;
    int out_wait    = 0;
    int mismatches  = 0;
    int n_beats     = 0;
    int n_ok        = 0;
    int n_bad       = 0;
    int n_nopkt     = 0;
    int n_lost      = 0;
    int n_writes    = 0;

    function automatic t_chan fit_chan(input t_chan v);
        if (v < cfg_min) return cfg_min;
        if (v > cfg_max) return cfg_max;
        return v;
    endfunction

    function automatic logic signed [15:0] aim_tilt(input t_chan ch);
        longint d;
        longint t;
        d = longint'(ch) - longint'(cfg_center);
        t = -(d * longint'(cfg_gain));
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        return 16'(t);
    endfunction

    function automatic void clear_frame();
        pos_count = 0;
        byte_sum  = 8'd0;
        header_ok = 1'b1;
    endfunction

    function automatic bit decode_beat(input logic f, input logic [7:0] b,
                                       output t_result rep);
        int p;
        int k;
        int y;
        bit has;
        has = 1'b0;
        p = pos_count;
        rep.status = ST_OK;
        if (f == FUNC_POLL) begin
            clear_frame();
            miss_count = miss_count + 16'd1;
            if (miss_count > cfg_loss) begin
                miss_count = '0;
                rep.status = ST_LOST;
                n_lost++;
            end else begin
                rep.status = ST_NOPKT;
                n_nopkt++;
            end
            has = 1'b1;
        end else begin
            if (p == 0 && b != HDR0) header_ok = 1'b0;
            if (p == 1 && b != HDR1) header_ok = 1'b0;
            if (p >= CH_FIRST_BYTE && p < CH_FIRST_BYTE + 2 * CHANNEL_COUNT) begin
                k = (p - CH_FIRST_BYTE) / 2;
                if (((p - CH_FIRST_BYTE) % 2) == 0) staged_ch[k][15:8] = b;
                else staged_ch[k][7:0] = b;
            end
            if (p + 1 >= FRAME_BYTES) begin
                miss_count = '0;
                if (header_ok && b == byte_sum) begin
                    for (int i = 0; i < CHANNEL_COUNT; i++) live_ch[i] = fit_chan(staged_ch[i]);
                    roll_tgt  = aim_tilt(live_ch[0]);
                    pitch_tgt = aim_tilt(live_ch[1]);
                    y = int'(yaw_acc);
                    if (live_ch[3] > cfg_yhigh) y = y + int'(cfg_ystep);
                    else if (live_ch[3] < cfg_ylow) y = y - int'(cfg_ystep);
                    if (y > 8388607) y = 8388607;
                    if (y < -8388608) y = -8388608;
                    yaw_acc = 24'(y);
                    rep.status = ST_OK;
                    n_ok++;
                end else begin
                    rep.status = ST_BAD;
                    n_bad++;
                end
                clear_frame();
                has = 1'b1;
            end else begin
                byte_sum  = byte_sum + b;
                pos_count = p + 1;
            end
        end
        rep.view.chan  = live_ch;
        rep.view.roll  = roll_tgt;
        rep.view.pitch = pitch_tgt;
        rep.view.yaw   = yaw_acc;
        return has;
    endfunction

    task automatic send_beat(input logic f, input logic [7:0] b);
        int gap;
        t_result rep;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.func      <= f;
        in_if.data_byte <= b;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        if (decode_beat(f, b, rep)) expected_reports.push_back(rep);
        n_beats++;
    endtask

    task automatic send_poll();
        send_beat(FUNC_POLL, 8'($urandom));
    endtask

    // cut < FRAME_BYTES sends only the first bytes of the frame
    task automatic send_frame(input t_chan_vec chans, input t_flaw flaw, input int cut);
        logic [7:0] fb [FRAME_BYTES];
        logic [7:0] acc;
        for (int i = 0; i < FRAME_BYTES; i++) fb[i] = 8'($urandom);
        if (flaw != FLAW_NOISE) begin
            fb[0] = HDR0;
            fb[1] = HDR1;
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                fb[CH_FIRST_BYTE + 2 * c]     = chans[c][15:8];
                fb[CH_FIRST_BYTE + 2 * c + 1] = chans[c][7:0];
            end
            if (flaw == FLAW_HDR0) fb[0] = fb[0] ^ 8'($urandom_range(1, 255));
            if (flaw == FLAW_HDR1) fb[1] = fb[1] ^ 8'($urandom_range(1, 255));
            acc = 8'd0;
            for (int i = 0; i < FRAME_BYTES - 1; i++) acc = acc + fb[i];
            fb[FRAME_BYTES - 1] = (flaw == FLAW_SUM) ? acc ^ 8'($urandom_range(1, 255)) : acc;
        end
        for (int i = 0; i < cut; i++) send_beat(FUNC_BYTE, fb[i]);
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        while (expected_reports.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        case (idx)
            CFG_CHAN_MIN:    cfg_min    = val;
            CFG_CHAN_MAX:    cfg_max    = val;
            CFG_CHAN_CENTER: cfg_center = val;
            CFG_TILT_GAIN:   cfg_gain   = val[7:0];
            CFG_YAW_HIGH:    cfg_yhigh  = val;
            CFG_YAW_LOW:     cfg_ylow   = val;
            CFG_YAW_STEP:    cfg_ystep  = val[9:0];
            CFG_LOSS_LIMIT:  cfg_loss   = val;
            default: ;
        endcase
        n_writes++;
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_chan_vec chans_fill(input t_chan v);
        t_chan_vec c;
        for (int i = 0; i < MAX_CH; i++) c[i] = v;
        return c;
    endfunction

    function automatic t_chan_vec rand_chans();
        t_chan_vec c;
        for (int i = 0; i < MAX_CH; i++) begin
            case ($urandom_range(0, 7))
                0:       c[i] = 16'h0000;
                1:       c[i] = 16'hFFFF;
                2, 3:    c[i] = 16'($urandom);
                default: c[i] = 16'($urandom_range(900, 2100));
            endcase
        end
        return c;
    endfunction

    function automatic logic [15:0] pick(input logic [15:0] lo, input logic [15:0] hi);
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    task automatic check_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    // result sink: random stall per beat, compare against oldest prediction
    always @(posedge i_clk) begin
        t_result exp_r;
        int w;
        if (!i_rst_n) begin
            out_if.ready <= 1'b1;
            out_wait     <= 0;
        end else if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: report with status %0d arrived, none expected",
                             $time, out_if.status);
            end else begin
                exp_r = expected_reports.pop_front();
                check_field("status", 24'(exp_r.status), 24'(out_if.status));
                check_field("roll_channel", 24'(exp_r.view.chan[0]),
                            24'(out_if.roll_channel));
                check_field("pitch_channel", 24'(exp_r.view.chan[1]),
                            24'(out_if.pitch_channel));
                check_field("throttle_channel", 24'(exp_r.view.chan[2]),
                            24'(out_if.throttle_channel));
                check_field("yaw_channel", 24'(exp_r.view.chan[3]),
                            24'(out_if.yaw_channel));
                check_field("aux_one", 24'(exp_r.view.chan[4]), 24'(out_if.aux_one));
                check_field("aux_two", 24'(exp_r.view.chan[5]), 24'(out_if.aux_two));
                check_field("aux_three", 24'(exp_r.view.chan[6]), 24'(out_if.aux_three));
                check_field("aux_four", 24'(exp_r.view.chan[7]), 24'(out_if.aux_four));
                check_field("roll_target", 24'(exp_r.view.roll), 24'(out_if.roll_target));
                check_field("pitch_target", 24'(exp_r.view.pitch),
                            24'(out_if.pitch_target));
                check_field("yaw_target", exp_r.view.yaw, out_if.yaw_target);
            end
            w = steady ? 0 : $urandom_range(0, 5);
            if (w == 0) begin
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= 1'b0;
                out_wait     <= w;
            end
        end else if (out_if.ready !== 1'b1) begin
            if (out_wait <= 1) out_if.ready <= 1'b1;
            else out_wait <= out_wait - 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                        (cfg_if.valid && cfg_if.ready))) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    task automatic test_defaults();
        t_chan_vec c;
        send_poll();
        c = chans_fill(16'd1500);
        c[0] = 16'h0000;
        c[1] = 16'hFFFF;
        c[2] = 16'd999;
        c[3] = 16'd1821;
        c[4] = 16'd1000;
        c[5] = 16'd2000;
        c[6] = 16'd2001;
        c[7] = 16'd1179;
        send_frame(c, FLAW_NONE, FRAME_BYTES);
    endtask

    // bad frames keep channels and targets, but still clear the loss count
    task automatic test_bad_frames();
        send_poll();
        send_poll();
        send_frame(rand_chans(), FLAW_HDR0, FRAME_BYTES);
        send_frame(rand_chans(), FLAW_HDR1, FRAME_BYTES);
        send_frame(rand_chans(), FLAW_SUM, FRAME_BYTES);
        send_poll();
    endtask

    task automatic test_partial_frames();
        send_frame(rand_chans(), FLAW_NONE, 10);
        send_poll();
        send_frame(rand_chans(), FLAW_NONE, FRAME_BYTES - 1);
        send_poll();
        send_frame(rand_chans(), FLAW_NONE, 1);
        send_poll();
        send_frame(rand_chans(), FLAW_NONE, FRAME_BYTES);
    endtask

    task automatic test_loss_limit();
        settle();
        write_reg(CFG_LOSS_LIMIT, 16'd2);
        repeat (7) send_poll();
        settle();
        write_reg(CFG_LOSS_LIMIT, 16'd0);
        repeat (2) send_poll();
        settle();
        write_reg(CFG_LOSS_LIMIT, 16'd800);
    endtask

    task automatic test_clamp_inverted();
        t_chan_vec c;
        settle();
        write_reg(CFG_CHAN_MIN, 16'd2000);
        write_reg(CFG_CHAN_MAX, 16'd1000);
        c = chans_fill(16'd1500);
        c[0] = 16'd500;
        c[1] = 16'd2500;
        c[2] = 16'd1000;
        c[3] = 16'd2000;
        send_frame(c, FLAW_NONE, FRAME_BYTES);
        settle();
        write_reg(CFG_CHAN_MIN, 16'h0000);
        write_reg(CFG_CHAN_MAX, 16'hFFFF);
    endtask

    // roll saturates low and pitch saturates high in one frame
    task automatic test_tilt_extremes();
        t_chan_vec c;
        settle();
        write_reg(CFG_CHAN_CENTER, 16'h8000);
        write_reg(CFG_TILT_GAIN, 16'h01FF);
        c = chans_fill(16'd1500);
        c[0] = 16'hFFFF;
        c[1] = 16'h0000;
        send_frame(c, FLAW_NONE, FRAME_BYTES);
    endtask

    // overlapping thresholds step up first
    task automatic test_yaw_rules();
        t_chan_vec c;
        settle();
        write_reg(CFG_YAW_HIGH, 16'd1200);
        write_reg(CFG_YAW_LOW, 16'd1800);
        write_reg(CFG_YAW_STEP, 16'hFFFF);
        c = chans_fill(16'd1500);
        send_frame(c, FLAW_NONE, FRAME_BYTES);
        settle();
        write_reg(CFG_YAW_HIGH, 16'hFFFF);
        write_reg(CFG_YAW_LOW, 16'hFFFF);
        send_frame(c, FLAW_NONE, FRAME_BYTES);
    endtask

    // at the top limit no poll reports link lost
    task automatic test_loss_top();
        settle();
        write_reg(CFG_LOSS_LIMIT, 16'hFFFF);
        steady = 1'b1;
        repeat (4) send_poll();
        steady = 1'b0;
    endtask

    task automatic test_random();
        int kind;
        repeat (2) begin
            settle();
            write_reg(CFG_CHAN_MIN,    pick(16'd0, 16'd1200));
            write_reg(CFG_CHAN_MAX,    pick(16'd1800, 16'd2500));
            write_reg(CFG_CHAN_CENTER, pick(16'd1000, 16'd2000));
            write_reg(CFG_TILT_GAIN,   pick(16'd0, 16'd300));
            write_reg(CFG_YAW_HIGH,    pick(16'd1000, 16'd2000));
            write_reg(CFG_YAW_LOW,     pick(16'd1000, 16'd2000));
            write_reg(CFG_YAW_STEP,    pick(16'd0, 16'd2000));
            write_reg(CFG_LOSS_LIMIT,  pick(16'd0, 16'd4));
            if ($urandom_range(0, 3) == 0)
                write_reg(t_cfg_idx'($urandom_range(8, 15)), 16'($urandom));
            repeat (2) begin
                steady = ($urandom_range(0, 3) == 0);
                kind   = $urandom_range(0, 19);
                if (kind < 12) begin
                    send_frame(rand_chans(), FLAW_NONE, FRAME_BYTES);
                end else if (kind < 15) begin
                    send_frame(rand_chans(), t_flaw'($urandom_range(1, 4)), FRAME_BYTES);
                end else if (kind < 17) begin
                    repeat ($urandom_range(1, 4)) send_poll();
                end else begin
                    send_frame(rand_chans(), FLAW_NONE, $urandom_range(1, FRAME_BYTES - 1));
                    send_poll();
                end
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.func       = FUNC_BYTE;
        in_if.data_byte  = 8'd0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = '0;
        cfg_if.data      = 16'd0;
        out_if.ready     = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_defaults();
        test_bad_frames();
        test_partial_frames();
        test_loss_limit();
        test_clamp_inverted();
        test_tilt_extremes();
        test_yaw_rules();
        test_loss_top();
        test_random();
        settle();

        $display("Covered %0d beats: %0d good frames, %0d bad frames,",
                 n_beats, n_ok, n_bad);
        $display("%0d no-packet polls, %0d link-lost polls, %0d register writes.",
                 n_nopkt, n_lost, n_writes);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
